/* rtl/lscf_pkg.sv */
// shared types, codes and solver microcode for the least-squares circle fit
// no dependencies
package lscf_pkg;

	localparam int MAX_POINTS_DEF       = 1024;
	localparam int COORD_BITS_DEF       = 12;
	localparam int RADIUS_FRAC_BITS_DEF = 8;
	localparam int MIN_POINTS           = 3;
	localparam int OUT_W                = 32;
	localparam int SQRT_IN_W            = 64;
	localparam int SQRT_STEPS           = 32;
	localparam int PC_W                 = 6;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_SQRT = 3'd4;

	localparam logic [1:0] TST_NONE = 2'd0;
	localparam logic [1:0] TST_DET  = 2'd1;
	localparam logic [1:0] TST_NUM  = 2'd2;
	localparam logic [1:0] TST_BIG  = 2'd3;

	localparam logic [1:0] CAP_NONE = 2'd0;
	localparam logic [1:0] CAP_CX   = 2'd1;
	localparam logic [1:0] CAP_CY   = 2'd2;
	localparam logic [1:0] CAP_R    = 2'd3;

	localparam logic [1:0] OUT_FAIL  = 2'd0;
	localparam logic [1:0] OUT_OK    = 2'd1;
	localparam logic [1:0] OUT_RZERO = 2'd2;
	localparam logic [1:0] OUT_RSAT  = 2'd3;

	typedef logic [4:0] src_t;

	localparam src_t R_T1   = 5'd0;
	localparam src_t R_T2   = 5'd1;
	localparam src_t R_S2   = 5'd2;
	localparam src_t R_C    = 5'd3;
	localparam src_t R_D    = 5'd4;
	localparam src_t R_G    = 5'd5;
	localparam src_t R_E    = 5'd6;
	localparam src_t R_H    = 5'd7;
	localparam src_t R_DET  = 5'd8;
	localparam src_t R_PX   = 5'd9;
	localparam src_t R_PY   = 5'd10;
	localparam src_t R_Q    = 5'd11;
	localparam src_t R_CX   = 5'd12;
	localparam src_t R_CY   = 5'd13;
	localparam src_t R_NUM  = 5'd14;
	localparam src_t R_RAD  = 5'd15;
	localparam src_t S_N    = 5'd16;
	localparam src_t S_SX   = 5'd17;
	localparam src_t S_SY   = 5'd18;
	localparam src_t S_SXX  = 5'd19;
	localparam src_t S_SYY  = 5'd20;
	localparam src_t S_SXY  = 5'd21;
	localparam src_t S_SX3  = 5'd22;
	localparam src_t S_SY3  = 5'd23;
	localparam src_t S_SXYY = 5'd24;
	localparam src_t S_SXXY = 5'd25;
	localparam src_t S_KF   = 5'd26;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] dst;
		src_t       src_a;
		src_t       src_b;
		logic [1:0] tst;
		logic [1:0] cap;
	} uinstr_t;

	typedef struct packed {
		logic       rd;
		logic       start;
		logic       step;
		logic       wb;
		logic       out_load;
		logic [1:0] out_mode;
		uinstr_t    ins;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic zero;
		logic nonpos;
		logic big;
	} dp_stat_t;

	localparam logic [PC_W-1:0] PROG_LAST = 6'd46;

	function automatic uinstr_t mk(input logic [2:0] op, input src_t dst, input src_t a,
		input src_t b, input logic [1:0] tst, input logic [1:0] cap);
		uinstr_t u;
		u.op    = op;
		u.dst   = dst[3:0];
		u.src_a = a;
		u.src_b = b;
		u.tst   = tst;
		u.cap   = cap;
		return u;
	endfunction

	function automatic uinstr_t ucode(input logic [PC_W-1:0] pc);
		uinstr_t u;
		unique case (pc)
			6'd0:  u = mk(OP_ADD, R_S2, S_SXX, S_SYY, TST_NONE, CAP_NONE);
			6'd1:  u = mk(OP_MUL, R_T1, S_N, S_SXX, TST_NONE, CAP_NONE);
			6'd2:  u = mk(OP_MUL, R_T2, S_SX, S_SX, TST_NONE, CAP_NONE);
			6'd3:  u = mk(OP_SUB, R_C, R_T1, R_T2, TST_NONE, CAP_NONE);
			6'd4:  u = mk(OP_MUL, R_T1, S_N, S_SXY, TST_NONE, CAP_NONE);
			6'd5:  u = mk(OP_MUL, R_T2, S_SX, S_SY, TST_NONE, CAP_NONE);
			6'd6:  u = mk(OP_SUB, R_D, R_T1, R_T2, TST_NONE, CAP_NONE);
			6'd7:  u = mk(OP_MUL, R_T1, S_N, S_SYY, TST_NONE, CAP_NONE);
			6'd8:  u = mk(OP_MUL, R_T2, S_SY, S_SY, TST_NONE, CAP_NONE);
			6'd9:  u = mk(OP_SUB, R_G, R_T1, R_T2, TST_NONE, CAP_NONE);
			6'd10: u = mk(OP_ADD, R_T1, S_SX3, S_SXYY, TST_NONE, CAP_NONE);
			6'd11: u = mk(OP_MUL, R_T1, S_N, R_T1, TST_NONE, CAP_NONE);
			6'd12: u = mk(OP_MUL, R_T2, R_S2, S_SX, TST_NONE, CAP_NONE);
			6'd13: u = mk(OP_SUB, R_E, R_T1, R_T2, TST_NONE, CAP_NONE);
			6'd14: u = mk(OP_ADD, R_T1, S_SXXY, S_SY3, TST_NONE, CAP_NONE);
			6'd15: u = mk(OP_MUL, R_T1, S_N, R_T1, TST_NONE, CAP_NONE);
			6'd16: u = mk(OP_MUL, R_T2, R_S2, S_SY, TST_NONE, CAP_NONE);
			6'd17: u = mk(OP_SUB, R_H, R_T1, R_T2, TST_NONE, CAP_NONE);
			6'd18: u = mk(OP_MUL, R_T1, R_C, R_G, TST_NONE, CAP_NONE);
			6'd19: u = mk(OP_MUL, R_T2, R_D, R_D, TST_NONE, CAP_NONE);
			6'd20: u = mk(OP_SUB, R_DET, R_T1, R_T2, TST_DET, CAP_NONE);
			6'd21: u = mk(OP_MUL, R_T1, R_E, R_G, TST_NONE, CAP_NONE);
			6'd22: u = mk(OP_MUL, R_T2, R_H, R_D, TST_NONE, CAP_NONE);
			6'd23: u = mk(OP_SUB, R_PX, R_T1, R_T2, TST_NONE, CAP_NONE);
			6'd24: u = mk(OP_MUL, R_T1, R_H, R_C, TST_NONE, CAP_NONE);
			6'd25: u = mk(OP_MUL, R_T2, R_E, R_D, TST_NONE, CAP_NONE);
			6'd26: u = mk(OP_SUB, R_PY, R_T1, R_T2, TST_NONE, CAP_NONE);
			6'd27: u = mk(OP_ADD, R_Q, R_DET, R_DET, TST_NONE, CAP_NONE);
			6'd28: u = mk(OP_DIV, R_CX, R_PX, R_Q, TST_NONE, CAP_CX);
			6'd29: u = mk(OP_DIV, R_CY, R_PY, R_Q, TST_NONE, CAP_CY);
			6'd30: u = mk(OP_MUL, R_T1, R_PX, R_PX, TST_NONE, CAP_NONE);
			6'd31: u = mk(OP_MUL, R_T2, R_PY, R_PY, TST_NONE, CAP_NONE);
			6'd32: u = mk(OP_ADD, R_T1, R_T1, R_T2, TST_NONE, CAP_NONE);
			6'd33: u = mk(OP_MUL, R_NUM, S_N, R_T1, TST_NONE, CAP_NONE);
			6'd34: u = mk(OP_MUL, R_T1, R_PX, S_SX, TST_NONE, CAP_NONE);
			6'd35: u = mk(OP_MUL, R_T2, R_PY, S_SY, TST_NONE, CAP_NONE);
			6'd36: u = mk(OP_ADD, R_T1, R_T1, R_T2, TST_NONE, CAP_NONE);
			6'd37: u = mk(OP_ADD, R_T2, R_Q, R_Q, TST_NONE, CAP_NONE);
			6'd38: u = mk(OP_MUL, R_T1, R_T2, R_T1, TST_NONE, CAP_NONE);
			6'd39: u = mk(OP_SUB, R_NUM, R_NUM, R_T1, TST_NONE, CAP_NONE);
			6'd40: u = mk(OP_MUL, R_T1, R_Q, R_Q, TST_NONE, CAP_NONE);
			6'd41: u = mk(OP_MUL, R_T2, R_T1, R_S2, TST_NONE, CAP_NONE);
			6'd42: u = mk(OP_ADD, R_NUM, R_NUM, R_T2, TST_NUM, CAP_NONE);
			6'd43: u = mk(OP_MUL, R_NUM, R_NUM, S_KF, TST_NONE, CAP_NONE);
			6'd44: u = mk(OP_MUL, R_T2, S_N, R_T1, TST_NONE, CAP_NONE);
			6'd45: u = mk(OP_DIV, R_T1, R_NUM, R_T2, TST_BIG, CAP_NONE);
			6'd46: u = mk(OP_SQRT, R_RAD, R_T1, R_T1, TST_NONE, CAP_R);
			default: u = mk(OP_ADD, R_T1, R_T1, R_T1, TST_NONE, CAP_NONE);
		endcase
		return u;
	endfunction

endpackage

/* rtl/lscf_accum.sv */
// point pipeline: products of each point and the running count and power sums
// depends on lscf_pkg
module lscf_accum
	import lscf_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [COORD_BITS-1:0]       x,
	input  logic [COORD_BITS-1:0]       y,
	input  logic                        clear,
	output logic                        busy,
	output logic [CNT_W-1:0]            count,
	output logic [CNT_W+COORD_BITS-1:0] sum_x,
	output logic [CNT_W+COORD_BITS-1:0] sum_y,
	output logic [CNT_W+2*COORD_BITS-1:0] sum_x_sq,
	output logic [CNT_W+2*COORD_BITS-1:0] sum_y_sq,
	output logic [CNT_W+2*COORD_BITS-1:0] sum_xy,
	output logic [CNT_W+3*COORD_BITS-1:0] sum_x_cube,
	output logic [CNT_W+3*COORD_BITS-1:0] sum_y_cube,
	output logic [CNT_W+3*COORD_BITS-1:0] sum_x_ysq,
	output logic [CNT_W+3*COORD_BITS-1:0] sum_xsq_y
);

	localparam int P2_W = 2 * COORD_BITS;
	localparam int P3_W = 3 * COORD_BITS;
	localparam int S1_W = CNT_W + COORD_BITS;
	localparam int S2_W = CNT_W + P2_W;
	localparam int S3_W = CNT_W + P3_W;

	logic                  v_s1, v_s2;
	logic [COORD_BITS-1:0] x_s1, y_s1, x_s2, y_s2;
	logic [P2_W-1:0]       xx_s1, yy_s1, xy_s1, xx_s2, yy_s2, xy_s2;
	logic [P3_W-1:0]       x3_s2, y3_s2, xyy_s2, xxy_s2;
	logic [CNT_W-1:0]      count_q;
	logic [S1_W-1:0]       sx_q, sy_q;
	logic [S2_W-1:0]       sxx_q, syy_q, sxy_q;
	logic [S3_W-1:0]       sx3_q, sy3_q, sxyy_q, sxxy_q;
	logic                  keep;

	assign keep = take && (count_q < CNT_W'(MAX_POINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= keep;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= x;
		y_s1   <= y;
		xx_s1  <= P2_W'(x) * P2_W'(x);
		yy_s1  <= P2_W'(y) * P2_W'(y);
		xy_s1  <= P2_W'(x) * P2_W'(y);
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		xx_s2  <= xx_s1;
		yy_s2  <= yy_s1;
		xy_s2  <= xy_s1;
		x3_s2  <= P3_W'(xx_s1) * P3_W'(x_s1);
		y3_s2  <= P3_W'(yy_s1) * P3_W'(y_s1);
		xyy_s2 <= P3_W'(yy_s1) * P3_W'(x_s1);
		xxy_s2 <= P3_W'(xx_s1) * P3_W'(y_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
			sx3_q   <= '0;
			sy3_q   <= '0;
			sxyy_q  <= '0;
			sxxy_q  <= '0;
		end else if (clear) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
			sx3_q   <= '0;
			sy3_q   <= '0;
			sxyy_q  <= '0;
			sxxy_q  <= '0;
		end else begin
			if (keep) begin
				count_q <= count_q + 1'b1;
			end
			if (v_s2) begin
				sx_q   <= sx_q + S1_W'(x_s2);
				sy_q   <= sy_q + S1_W'(y_s2);
				sxx_q  <= sxx_q + S2_W'(xx_s2);
				syy_q  <= syy_q + S2_W'(yy_s2);
				sxy_q  <= sxy_q + S2_W'(xy_s2);
				sx3_q  <= sx3_q + S3_W'(x3_s2);
				sy3_q  <= sy3_q + S3_W'(y3_s2);
				sxyy_q <= sxyy_q + S3_W'(xyy_s2);
				sxxy_q <= sxxy_q + S3_W'(xxy_s2);
			end
		end
	end

	assign busy       = v_s1 | v_s2;
	assign count      = count_q;
	assign sum_x      = sx_q;
	assign sum_y      = sy_q;
	assign sum_x_sq   = sxx_q;
	assign sum_y_sq   = syy_q;
	assign sum_xy     = sxy_q;
	assign sum_x_cube = sx3_q;
	assign sum_y_cube = sy3_q;
	assign sum_x_ysq  = sxyy_q;
	assign sum_xsq_y  = sxxy_q;

endmodule

/* rtl/lscf_dp.sv */
// solver datapath: operand store, shift-add multiplier, restoring divider, square root
// depends on lscf_pkg
module lscf_dp
	import lscf_pkg::*;
#(
	parameter int COORD_BITS       = COORD_BITS_DEF,
	parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_BITS_DEF,
	parameter int CNT_W            = 11
) (
	input  logic                          clk,
	input  dp_cmd_t                       cmd,
	output dp_stat_t                      stat,
	input  logic [CNT_W-1:0]              count,
	input  logic [CNT_W+COORD_BITS-1:0]   sum_x,
	input  logic [CNT_W+COORD_BITS-1:0]   sum_y,
	input  logic [CNT_W+2*COORD_BITS-1:0] sum_x_sq,
	input  logic [CNT_W+2*COORD_BITS-1:0] sum_y_sq,
	input  logic [CNT_W+2*COORD_BITS-1:0] sum_xy,
	input  logic [CNT_W+3*COORD_BITS-1:0] sum_x_cube,
	input  logic [CNT_W+3*COORD_BITS-1:0] sum_y_cube,
	input  logic [CNT_W+3*COORD_BITS-1:0] sum_x_ysq,
	input  logic [CNT_W+3*COORD_BITS-1:0] sum_xsq_y,
	output logic [3*OUT_W-1:0]            out_data,
	output logic                          out_ok
);

	localparam int BIG_W = 9 * CNT_W + 10 * COORD_BITS + 2 * RADIUS_FRAC_BITS + 12;
	localparam int CC_W  = $clog2(BIG_W + 1);
	localparam int SQ_W  = SQRT_STEPS + 2;

	logic [BIG_W-1:0] mem_q [16];
	logic [BIG_W-1:0] rda_q, rdb_q, opa, opb, mag_a, mag_b;
	logic [BIG_W-1:0] ma_q, mb_q, acc_q, rem_q, res, div_sh, div_rem;
	logic [CC_W-1:0]  cnt_q;
	logic             neg_q, div_ge, sq_ge, fits, dn_c, res_zero;
	logic [SQ_W-1:0]  sq_sh, sq_trial, sq_rem;
	logic [OUT_W-1:0] cx_q, cy_q, rad_q, sat_res;

	always_comb begin
		unique case (cmd.ins.src_a)
			S_N:     opa = BIG_W'(count);
			S_SX:    opa = BIG_W'(sum_x);
			S_SY:    opa = BIG_W'(sum_y);
			S_SXX:   opa = BIG_W'(sum_x_sq);
			S_SYY:   opa = BIG_W'(sum_y_sq);
			S_SXY:   opa = BIG_W'(sum_xy);
			S_SX3:   opa = BIG_W'(sum_x_cube);
			S_SY3:   opa = BIG_W'(sum_y_cube);
			S_SXYY:  opa = BIG_W'(sum_x_ysq);
			S_SXXY:  opa = BIG_W'(sum_xsq_y);
			S_KF:    opa = BIG_W'(1) << (2 * RADIUS_FRAC_BITS);
			default: opa = rda_q;
		endcase
		unique case (cmd.ins.src_b)
			S_N:     opb = BIG_W'(count);
			S_SX:    opb = BIG_W'(sum_x);
			S_SY:    opb = BIG_W'(sum_y);
			S_SXX:   opb = BIG_W'(sum_x_sq);
			S_SYY:   opb = BIG_W'(sum_y_sq);
			S_SXY:   opb = BIG_W'(sum_xy);
			S_SX3:   opb = BIG_W'(sum_x_cube);
			S_SY3:   opb = BIG_W'(sum_y_cube);
			S_SXYY:  opb = BIG_W'(sum_x_ysq);
			S_SXXY:  opb = BIG_W'(sum_xsq_y);
			S_KF:    opb = BIG_W'(1) << (2 * RADIUS_FRAC_BITS);
			default: opb = rdb_q;
		endcase
	end

	assign mag_a = opa[BIG_W-1] ? -opa : opa;
	assign mag_b = opb[BIG_W-1] ? -opb : opb;

	// restoring divide step, quotient shifts into ma_q
	assign div_sh  = {rem_q[BIG_W-2:0], ma_q[BIG_W-1]};
	assign div_ge  = div_sh >= mb_q;
	assign div_rem = div_ge ? div_sh - mb_q : div_sh;

	// square root step, two radicand bits per step
	assign sq_sh    = {rem_q[SQ_W-3:0], ma_q[SQRT_IN_W-1 -: 2]};
	assign sq_trial = {mb_q[SQ_W-3:0], 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;
	assign sq_rem   = sq_ge ? sq_sh - sq_trial : sq_sh;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rda_q <= mem_q[cmd.ins.src_a[3:0]];
			rdb_q <= mem_q[cmd.ins.src_b[3:0]];
		end
		if (cmd.wb) begin
			mem_q[cmd.ins.dst] <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			unique case (cmd.ins.op)
				OP_ADD: acc_q <= opa + opb;
				OP_SUB: acc_q <= opa - opb;
				OP_MUL: begin
					acc_q <= '0;
					ma_q  <= mag_a;
					mb_q  <= mag_b;
					neg_q <= opa[BIG_W-1] ^ opb[BIG_W-1];
				end
				OP_DIV: begin
					rem_q <= '0;
					ma_q  <= mag_a;
					mb_q  <= mag_b;
					neg_q <= opa[BIG_W-1] ^ opb[BIG_W-1];
					cnt_q <= CC_W'(BIG_W);
				end
				OP_SQRT: begin
					rem_q <= '0;
					ma_q  <= opa;
					mb_q  <= '0;
					cnt_q <= CC_W'(SQRT_STEPS);
				end
				default: acc_q <= opa;
			endcase
		end else if (cmd.step) begin
			unique case (cmd.ins.op)
				OP_MUL: begin
					if (mb_q[0]) begin
						acc_q <= acc_q + ma_q;
					end
					ma_q <= ma_q << 1;
					mb_q <= mb_q >> 1;
				end
				OP_DIV: begin
					rem_q <= div_rem;
					ma_q  <= {ma_q[BIG_W-2:0], div_ge};
					cnt_q <= cnt_q - 1'b1;
				end
				OP_SQRT: begin
					rem_q <= BIG_W'(sq_rem);
					ma_q  <= ma_q << 2;
					mb_q  <= BIG_W'({mb_q[SQRT_STEPS-2:0], sq_ge});
					cnt_q <= cnt_q - 1'b1;
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.ins.op)
			OP_MUL:  begin
				res  = neg_q ? -acc_q : acc_q;
				dn_c = (mb_q == '0);
			end
			OP_DIV:  begin
				res  = neg_q ? -ma_q : ma_q;
				dn_c = (cnt_q == '0);
			end
			OP_SQRT: begin
				res  = mb_q;
				dn_c = (cnt_q == '0);
			end
			default: begin
				res  = acc_q;
				dn_c = 1'b1;
			end
		endcase
	end

	assign res_zero = (res == '0);
	assign stat     = '{done: dn_c, zero: res_zero, nonpos: res[BIG_W-1] | res_zero,
		big: |res[BIG_W-1:SQRT_IN_W]};

	assign fits    = (&res[BIG_W-1:OUT_W-1]) | ~(|res[BIG_W-1:OUT_W-1]);
	assign sat_res = fits ? res[OUT_W-1:0] :
		(res[BIG_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}});

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			unique case (cmd.ins.cap)
				CAP_CX:  cx_q  <= sat_res;
				CAP_CY:  cy_q  <= sat_res;
				CAP_R:   rad_q <= res[OUT_W-1:0];
				default: cx_q  <= cx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_mode)
				OUT_OK: begin
					out_data <= {rad_q, cy_q, cx_q};
					out_ok   <= 1'b1;
				end
				OUT_RZERO: begin
					out_data <= {{OUT_W{1'b0}}, cy_q, cx_q};
					out_ok   <= 1'b1;
				end
				OUT_RSAT: begin
					out_data <= {{OUT_W{1'b1}}, cy_q, cx_q};
					out_ok   <= 1'b1;
				end
				default: begin
					out_data <= '0;
					out_ok   <= 1'b0;
				end
			endcase
		end
	end

endmodule

/* rtl/lscf_ctrl.sv */
// controller: input handshake, drain wait, microcode sequencing, result handshake
// depends on lscf_pkg
module lscf_ctrl
	import lscf_pkg::*;
#(
	parameter int CNT_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  logic             acc_busy,
	input  logic [CNT_W-1:0] acc_count,
	output logic             acc_take,
	output logic             acc_clear,
	output dp_cmd_t          cmd,
	input  dp_stat_t         stat
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DRAIN = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]      state_q, state_d;
	logic [PC_W-1:0] pc_q, pc_d;
	logic [1:0]      mode_q, mode_d;
	logic            m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign acc_take = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d      = state_q;
		pc_d         = pc_q;
		mode_d       = mode_q;
		acc_clear    = 1'b0;
		cmd          = '0;
		cmd.ins      = ucode(pc_q);
		cmd.out_mode = mode_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tlast) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!acc_busy) begin
					pc_d = '0;
					if (acc_count < CNT_W'(MIN_POINTS)) begin
						mode_d  = OUT_FAIL;
						state_d = ST_FIN;
					end else begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				cmd.rd  = 1'b1;
				state_d = ST_START;
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = ST_RUN;
			end
			ST_RUN: begin
				if (stat.done) begin
					cmd.wb = 1'b1;
					priority if (cmd.ins.tst == TST_DET && stat.zero) begin
						mode_d  = OUT_FAIL;
						state_d = ST_FIN;
					end else if (cmd.ins.tst == TST_NUM && stat.nonpos) begin
						mode_d  = OUT_RZERO;
						state_d = ST_FIN;
					end else if (cmd.ins.tst == TST_BIG && stat.big) begin
						mode_d  = OUT_RSAT;
						state_d = ST_FIN;
					end else if (pc_q == PROG_LAST) begin
						mode_d  = OUT_OK;
						state_d = ST_FIN;
					end else begin
						pc_d    = pc_q + 1'b1;
						state_d = ST_FETCH;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					acc_clear    = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pc_q       <= '0;
			mode_q     <= OUT_FAIL;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			mode_q  <= mode_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/least_squares_circle_fit.sv */
// least-squares circle fit over a stream of points, one fit per set
// throughput: one point per cycle within a set; no point is taken from the last point on
// sequence: a drain wait for the point pipeline, then the microcode solve on a datapath of W bits,
// W = 9*clog2(MAX_POINTS+1) + 10*COORD_BITS + 2*RADIUS_FRAC_BITS + 12, then a result load
// that waits for a held result to be taken; fewer than three points skip the solve
// reset: asynchronous active-low arst_n clears the count, the sums and all control state
module least_squares_circle_fit
	import lscf_pkg::*;
#(
	parameter int MAX_POINTS       = MAX_POINTS_DEF,
	parameter int COORD_BITS       = COORD_BITS_DEF,
	parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,  // point_x, point_y
	input  logic                                  s_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [3*OUT_W-1:0]                    m_tdata,  // center_x, center_y, radius_fixed
	output logic                                  m_tuser   // fit_ok
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic                           acc_busy, acc_take, acc_clear;
	logic [CNT_W-1:0]               count;
	logic [CNT_W+COORD_BITS-1:0]    sum_x, sum_y;
	logic [CNT_W+2*COORD_BITS-1:0]  sum_x_sq, sum_y_sq, sum_xy;
	logic [CNT_W+3*COORD_BITS-1:0]  sum_x_cube, sum_y_cube, sum_x_ysq, sum_xsq_y;
	dp_cmd_t                        cmd;
	dp_stat_t                       stat;

	lscf_accum #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.CNT_W      (CNT_W)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (acc_take),
		.x          (s_tdata[COORD_BITS-1:0]),
		.y          (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.clear      (acc_clear),
		.busy       (acc_busy),
		.count      (count),
		.sum_x      (sum_x),
		.sum_y      (sum_y),
		.sum_x_sq   (sum_x_sq),
		.sum_y_sq   (sum_y_sq),
		.sum_xy     (sum_xy),
		.sum_x_cube (sum_x_cube),
		.sum_y_cube (sum_y_cube),
		.sum_x_ysq  (sum_x_ysq),
		.sum_xsq_y  (sum_xsq_y)
	);

	lscf_ctrl #(
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tlast   (s_tlast),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.acc_busy  (acc_busy),
		.acc_count (count),
		.acc_take  (acc_take),
		.acc_clear (acc_clear),
		.cmd       (cmd),
		.stat      (stat)
	);

	lscf_dp #(
		.COORD_BITS       (COORD_BITS),
		.RADIUS_FRAC_BITS (RADIUS_FRAC_BITS),
		.CNT_W            (CNT_W)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.stat       (stat),
		.count      (count),
		.sum_x      (sum_x),
		.sum_y      (sum_y),
		.sum_x_sq   (sum_x_sq),
		.sum_y_sq   (sum_y_sq),
		.sum_xy     (sum_xy),
		.sum_x_cube (sum_x_cube),
		.sum_y_cube (sum_y_cube),
		.sum_x_ysq  (sum_x_ysq),
		.sum_xsq_y  (sum_xsq_y),
		.out_data   (m_tdata),
		.out_ok     (m_tuser)
	);

endmodule

/* rtl/lscf_checker.sv */
// port-level checks for the circle fit, bound to the top level
// depends on lscf_pkg and least_squares_circle_fit
module lscf_checker
	import lscf_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
	input logic                              s_tlast,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [3*OUT_W-1:0]                m_tdata,
	input logic                              m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("failed fit with nonzero fields");

	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("request taken after closing point");

	a_stream_on: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("point stream stalled mid set");

endmodule

bind least_squares_circle_fit lscf_checker #(.COORD_BITS(COORD_BITS)) u_lscf_checker (.*);

/* test/tb_top.sv */
// self-checking testbench for least_squares_circle_fit: streams point sets, predicts each
// circle fit with wide signed integer arithmetic and checks every fit result field by field
// depends on rtl/lscf_pkg.sv and rtl/least_squares_circle_fit.sv
`timescale 1ns / 100ps

module tb_top;
	import lscf_pkg::*;

	localparam int CW        = COORD_BITS_DEF;
	localparam int DW        = ((2*CW+7)/8)*8;
	localparam int NPTS      = MAX_POINTS_DEF;
	localparam int IDLE_MAX  = 60000;
	localparam int HOLD_FROM = 40000;
	localparam int HOLD_LEN  = 20000;

	typedef struct {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          last;
		logic          drain_first;
	} point_t;

	typedef struct {
		logic        ok;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] rad;
	} fit_t;

	typedef logic signed [511:0] wide_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DW-1:0]     s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [3*OUT_W-1:0] m_tdata;
	logic              m_tuser;

	point_t pending_points[$];
	fit_t   expected_fits[$];
	int     errors = 0;

	// running sums of the set being collected
	logic [63:0] n_pts, s_x, s_y, s_xx, s_yy, s_x3, s_y3, s_xy, s_xyy, s_xxy;

	least_squares_circle_fit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] sat32(input wide_t v);
		if (v > wide_t'(64'sh7FFFFFFF)) return 32'h7FFFFFFF;
		if (v < -wide_t'(64'sh80000000)) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic fit_t solve_circle();
		fit_t f;
		wide_t n, sx, sy, sxx, syy, sxy, s2, c, d, e, g, h, det, px, py, q, num, den, t;
		f = '{1'b0, 32'd0, 32'd0, 32'd0};
		if (n_pts < MIN_POINTS) return f;
		n = wide_t'(n_pts); sx = wide_t'(s_x); sy = wide_t'(s_y);
		sxx = wide_t'(s_xx); syy = wide_t'(s_yy); sxy = wide_t'(s_xy);
		s2 = sxx + syy;
		c = n*sxx - sx*sx;
		d = n*sxy - sx*sy;
		g = n*syy - sy*sy;
		e = n*(wide_t'(s_x3) + wide_t'(s_xyy)) - s2*sx;
		h = n*(wide_t'(s_xxy) + wide_t'(s_y3)) - s2*sy;
		det = c*g - d*d;
		if (det == 0) return f;
		px = e*g - h*d;
		py = h*c - e*d;
		q = det + det;
		if (q < 0) begin
			q = -q; px = -px; py = -py;
		end
		f.ok = 1'b1;
		f.cx = sat32(px / q);
		f.cy = sat32(py / q);
		num = n*(px*px + py*py) - (q+q)*(px*sx + py*sy) + q*q*s2;
		if (num <= 0) return f;
		num = num * (wide_t'(1) << (2*RADIUS_FRAC_BITS_DEF));
		den = n*q*q;
		t = num / den;
		if (t >= (wide_t'(1) << 64)) f.rad = 32'hFFFFFFFF;
		else f.rad = 32'(isqrt(t[63:0]));
		return f;
	endfunction

	task automatic clear_sums();
		n_pts = 0; s_x = 0; s_y = 0; s_xx = 0; s_yy = 0;
		s_x3 = 0; s_y3 = 0; s_xy = 0; s_xyy = 0; s_xxy = 0;
	endtask

	task automatic take_point(input point_t p);
		logic [63:0] x, y;
		fit_t f;
		x = 64'(p.x);
		y = 64'(p.y);
		if (n_pts < NPTS) begin
			n_pts += 1;
			s_x += x; s_y += y;
			s_xx += x*x; s_yy += y*y;
			s_x3 += x*x*x; s_y3 += y*y*y;
			s_xy += x*y; s_xyy += x*y*y; s_xxy += x*x*y;
		end
		if (p.last) begin
			f = solve_circle();
			expected_fits = {expected_fits, f};
			clear_sums();
		end
	endtask

	task automatic add_point(input int x, input int y, input bit last, input bit drain = 0);
		point_t p;
		p.x = x[CW-1:0];
		p.y = y[CW-1:0];
		p.last = last;
		p.drain_first = drain;
		pending_points = {pending_points, p};
	endtask

	// one set of n points: 0 on a circle, 1 scattered, 2 on a line or a single spot
	task automatic add_set(input int n, input int kind, input bit drain);
		int r, ccx, ccy, dx, dy, x, y, x0, y0, ax;
		r = $urandom_range(1, 2047);
		ccx = $urandom_range(r, 4095 - r);
		ccy = $urandom_range(r, 4095 - r);
		x0 = $urandom_range(0, 4095);
		y0 = $urandom_range(0, 4095);
		ax = $urandom_range(0, 2);
		for (int i = 0; i < n; i++) begin
			if (kind == 0) begin
				dx = int'($urandom_range(0, 2*r)) - r;
				dy = int'(isqrt(64'(r*r - dx*dx)));
				if ($urandom_range(0, 1)) dy = -dy;
				x = ccx + dx;
				y = ccy + dy;
				if ($urandom_range(0, 3) == 0) begin
					x = x + int'($urandom_range(0, 2)) - 1;
					y = y + int'($urandom_range(0, 2)) - 1;
				end
				x = (x < 0) ? 0 : (x > 4095) ? 4095 : x;
				y = (y < 0) ? 0 : (y > 4095) ? 4095 : y;
			end else if (kind == 1) begin
				x = $urandom_range(0, 4095);
				y = $urandom_range(0, 4095);
			end else begin
				x = (ax == 1) ? x0 : $urandom_range(0, 4095);
				y = (ax == 0) ? y0 : (ax == 1) ? $urandom_range(0, 4095) : y0;
				if (ax == 2) x = x0;
			end
			add_point(x, y, i == n - 1, drain && i == 0);
		end
	endtask

	// stimulus
	initial begin
		int sets, n, kind;
		clear_sums();
		// too few points
		add_point(4095, 4095, 1);
		add_point(0, 0, 0);
		add_point(4095, 0, 1);
		// singular: collinear and one repeated spot
		add_point(0, 0, 0); add_point(100, 100, 0); add_point(4095, 4095, 1);
		add_point(7, 9, 0); add_point(7, 9, 0); add_point(7, 9, 0); add_point(7, 9, 1);
		// corners
		add_point(0, 0, 0); add_point(4095, 0, 0); add_point(0, 4095, 0);
		add_point(4095, 4095, 1);
		// nearly collinear, far centre
		add_point(0, 0, 0); add_point(1, 0, 0); add_point(4095, 1, 1);
		add_point(0, 0, 0); add_point(4095, 1, 0); add_point(2048, 1, 1, 1);
		// random sets
		sets = 0;
		while (pending_points.size() < 1850) begin
			sets++;
			kind = $urandom_range(0, 9);
			kind = (kind < 7) ? 0 : (kind < 9) ? 1 : 2;
			n = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
			if (sets == 60) n = NPTS + 20;
			add_set(n, kind, sets % 40 == 0);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (pending_points.size() != 0 || s_tvalid ||
			expected_fits.size() != 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// point sender: bursts with gaps, optional wait for all fits before a set
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		logic nv;
		nv = s_tvalid;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				take_point(pending_points.pop_front());
				if (burst_left > 0) burst_left--;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
				end
				if (gap_left > 0) begin
					gap_left--;
					nv = 1'b0;
				end else if (pending_points.size() != 0 &&
						!(pending_points[0].drain_first && expected_fits.size() != 0)) begin
					nv = 1'b1;
					s_tdata <= {pending_points[0].y, pending_points[0].x};
					s_tlast <= pending_points[0].last;
				end else begin
					nv = 1'b0;
				end
			end
		end
		s_tvalid <= nv;
	end

	// fit receiver and checker
	int rx_cycles = 0;
	int rx_mode = 0;
	always @(posedge clk) begin
		fit_t want;
		if (arst_n) begin
			rx_cycles++;
			if (m_tvalid && m_tready) begin
				if (expected_fits.size() == 0) begin
					$error("unexpected fit result");
					errors++;
				end else begin
					want = expected_fits.pop_front();
					if (m_tuser !== want.ok) begin
						$error("fit_ok: expected %0d, got %0d", want.ok, m_tuser);
						errors++;
					end
					if (m_tdata[31:0] !== want.cx) begin
						$error("center_x: expected %0d, got %0d",
							$signed(want.cx), $signed(m_tdata[31:0]));
						errors++;
					end
					if (m_tdata[63:32] !== want.cy) begin
						$error("center_y: expected %0d, got %0d",
							$signed(want.cy), $signed(m_tdata[63:32]));
						errors++;
					end
					if (m_tdata[95:64] !== want.rad) begin
						$error("radius_fixed: expected %0d, got %0d", want.rad, m_tdata[95:64]);
						errors++;
					end
				end
			end
			if (rx_cycles % 500 == 0) rx_mode = $urandom_range(0, 2);
			if (rx_cycles >= HOLD_FROM && rx_cycles < HOLD_FROM + HOLD_LEN)
				m_tready <= 1'b0;
			else if (rx_mode == 0)
				m_tready <= 1'b1;
			else if (rx_mode == 1)
				m_tready <= 1'($urandom_range(0, 1));
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog on cycles without any request moving
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_MAX) begin
			$display("*** FAILED ***");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule

/* least_squares_circle_fit.f */
rtl/lscf_pkg.sv
rtl/lscf_accum.sv
rtl/lscf_dp.sv
rtl/lscf_ctrl.sv
rtl/least_squares_circle_fit.sv
rtl/lscf_checker.sv
test/tb_top.sv
